// ===== rtl/cwd_pkg.sv =====
// Package for the CRC-8 checked word deframer: word types, phase codes,
// CRC constants and the byte-wide CRC update. No dependencies.
`default_nettype none

package cwd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int unsigned WPR_W = 5;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_read;
  } cwd_in_t;

  typedef struct packed {
    logic [15:0] data_word;
    logic        word_crc_ok;
    logic        read_ok;
    logic        last_word;
  } cwd_out_t;

  // MSB-first CRC-8 over one byte, eight shift steps of the polynomial
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cwd_core.sv =====
// Deframer state: byte phase, running CRC, held data bytes, word count and
// read error flag. Depends on cwd_pkg.
`default_nettype none

module cwd_core #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire cwd_pkg::cwd_in_t          item,
  input  wire logic [cwd_pkg::WPR_W-1:0] words_per_read,
  output logic                           emit,
  output cwd_pkg::cwd_out_t              result
);
  import cwd_pkg::*;

  localparam logic [WPR_W+1:0] MaxWords = (WPR_W+2)'(MAX_WORDS);

  phase_t           phase_r, phase_nxt, phase_eff;
  logic [7:0]       crc_r, crc_nxt, crc_eff;
  logic [7:0]       high_r, high_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [WPR_W-1:0] widx_r, widx_nxt, widx_eff;
  logic             err_r, err_nxt, err_eff;
  logic [WPR_W-1:0] count;
  logic             ok, err_now, last;

  // a start mark clears the read before the byte is taken
  always_comb begin
    phase_eff = item.start_of_read ? PH_HIGH : phase_r;
    crc_eff   = item.start_of_read ? CRC_INIT : crc_r;
    widx_eff  = item.start_of_read ? '0 : widx_r;
    err_eff   = item.start_of_read ? 1'b0 : err_r;
    count     = (words_per_read == '0) ? WPR_W'(1) : words_per_read;
    ok        = (crc_eff == item.rx_byte);
    err_now   = err_eff | ~ok;
    last      = ({1'b0, widx_eff} + (WPR_W+1)'(1)) >= {1'b0, count};
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    widx_nxt  = widx_eff;
    err_nxt   = err_eff;
    case (phase_eff)
      PH_LOW: begin
        low_nxt   = item.rx_byte;
        crc_nxt   = crc8_byte(crc_eff, item.rx_byte);
        phase_nxt = PH_CRC;
      end
      PH_CRC: begin
        crc_nxt   = CRC_INIT;
        phase_nxt = PH_HIGH;
        widx_nxt  = last ? '0 : widx_eff + WPR_W'(1);
        err_nxt   = last ? 1'b0 : err_now;
      end
      default: begin
        high_nxt  = item.rx_byte;
        crc_nxt   = crc8_byte(CRC_INIT, item.rx_byte);
        phase_nxt = PH_LOW;
      end
    endcase
  end

  // outputs
  always_comb begin
    emit               = 1'b0;
    result.data_word   = {high_r, low_r};
    result.word_crc_ok = ok;
    result.read_ok     = ~err_now && ({2'b00, count} <= MaxWords);
    result.last_word   = last;
    case (phase_eff)
      PH_CRC:  emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HIGH;
      crc_r   <= CRC_INIT;
      widx_r  <= '0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      widx_r  <= widx_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc8_checked_word_deframer.sv =====
// Top level of the CRC-8 checked word deframer: input register, config
// register, output register. Depends on cwd_pkg and cwd_core.
// Path: a word goes from the input register to the output register when its
// CRC byte moves on, and its CRC byte waits while out_* holds a stalled word.
// Throughput: one byte per cycle unless a CRC byte waits for a free output
// register; the state updates in one pass through cwd_core.
// Reset: synchronous, active low; clears phase, CRC, count, error and sets
// words_per_read to 1.
`default_nettype none

module crc8_checked_word_deframer #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cwd_pkg::cwd_in_t          in_word,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cwd_pkg::cwd_out_t              out_word,
  input  wire logic                      cfg_wr_en,
  input  wire logic [cwd_pkg::WPR_W-1:0] cfg_wr_data
);
  import cwd_pkg::*;

  logic             s1_vld_r, s1_vld_nxt;
  cwd_in_t          s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  cwd_out_t         out_word_r;
  logic [WPR_W-1:0] wpr_r;
  logic             in_acc, s1_go, out_load, out_free, emit;
  cwd_out_t         result;

  cwd_core #(.MAX_WORDS(MAX_WORDS)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_go),
    .item           (s1_item_r),
    .words_per_read (wpr_r),
    .emit           (emit),
    .result         (result)
  );

  always_comb begin
    out_free      = ~out_valid_r | ~out_stall;
    s1_go         = s1_vld_r & (~emit | out_free);
    out_load      = s1_go & emit;
    in_stall      = s1_vld_r & ~s1_go;
    in_acc        = in_valid & ~in_stall;
    s1_vld_nxt    = in_acc | (s1_vld_r & ~s1_go);
    out_valid_nxt = out_load | (out_valid_r & out_stall);
    out_valid     = out_valid_r;
    out_word      = out_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      wpr_r       <= WPR_W'(1);
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wpr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_word;
    end
    if (out_load) begin
      out_word_r <= result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !out_load)
    else $error("held word overwritten");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_go |=> s1_vld_r && $stable(s1_item_r))
    else $error("input register lost a byte");

  a_read_ok_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.read_ok |-> out_word_r.word_crc_ok)
    else $error("read_ok set on a failed word");

endmodule

`default_nettype wire
